@@ hdl/force_aligned_assist_pd_filter_defines.svh @@
// Assertion macros for the force aligned assist block.
`ifndef FORCE_ALIGNED_ASSIST_PD_FILTER_DEFINES_SVH
`define FORCE_ALIGNED_ASSIST_PD_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

`define FAAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define FAAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define FAAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FAAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ hdl/faap_pkg.sv @@
package faap_pkg;

    typedef logic signed [33:0] mul_op_t;
    typedef logic signed [67:0] prod_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [5:0] {
        S_IDLE, S_KNEE, S_SQ0, S_SQ1, S_SQ2, S_SQ3, S_NORM, S_DIV_ISS, S_DIV,
        S_DOT0, S_DOT1, S_DOT2, S_DOT3, S_CSQ, S_CSQ2, S_YSQ, S_CORD, S_DES,
        S_DDIV, S_ALPHA, S_E_ISS, S_E_GET, S_PD_ISS, S_PD_A, S_PD_B, S_F_ISS,
        S_F_A, S_F_B, S_V_ISS, S_V_A, S_V_B, S_V_C, S_K_ISS, S_K_GET, S_OUT
    } state_t;

    localparam logic [2:0] CFG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] CFG_DERIV_GAIN = 3'd1;
    localparam logic [2:0] CFG_FILTER     = 3'd2;
    localparam logic [2:0] CFG_TIBIA      = 3'd3;
    localparam logic [2:0] CFG_INV_TIBIA  = 3'd4;
    localparam logic [2:0] CFG_ANGLE_LIM  = 3'd5;
    localparam logic [2:0] CFG_ALPHA_STEP = 3'd6;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [4:0]  CORDIC_LAST = 5'd16;
    localparam logic [63:0] ONE_Q60     = 64'h1000_0000_0000_0000;
    localparam prod_t       MAX32       = 68'sd2147483647;
    localparam prod_t       MIN32       = -68'sd2147483648;
    localparam prod_t       ONE_Q30_W   = 68'sd1073741824;
    localparam prod_t       NEG_Q30_W   = -68'sd1073741824;

    function automatic logic [15:0] atan_q16(input logic [4:0] i);
        logic [15:0] r;
        unique case (i)
            5'd0:    r = 16'd51472;
            5'd1:    r = 16'd30386;
            5'd2:    r = 16'd16055;
            5'd3:    r = 16'd8150;
            5'd4:    r = 16'd4091;
            5'd5:    r = 16'd2047;
            5'd6:    r = 16'd1024;
            5'd7:    r = 16'd512;
            5'd8:    r = 16'd256;
            5'd9:    r = 16'd128;
            5'd10:   r = 16'd64;
            5'd11:   r = 16'd32;
            5'd12:   r = 16'd16;
            5'd13:   r = 16'd8;
            5'd14:   r = 16'd4;
            5'd15:   r = 16'd2;
            5'd16:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

    // round to nearest, ties up
    function automatic prod_t rnd_shift(input prod_t v, input int unsigned sh);
        prod_t half;
        half = prod_t'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic logic signed [31:0] sat32(input prod_t v);
        logic signed [31:0] r;
        if (v > MAX32)
            r = 32'sh7FFF_FFFF;
        else if (v < MIN32)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
        return (v == 32'sh8000_0000) ? 32'sh7FFF_FFFF : -v;
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic mul_op_t sx32(input logic signed [31:0] v);
        return {{2{v[31]}}, v};
    endfunction

    function automatic mul_op_t sx33(input logic signed [32:0] v);
        return {v[32], v};
    endfunction

    function automatic logic signed [32:0] sub33(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return {a[31], a} - {b[31], b};
    endfunction

    function automatic logic signed [31:0] clip32(input prod_t p,
                                                  input logic signed [31:0] f);
        prod_t v;
        prod_t fw;
        v  = rnd_shift(p, 30);
        fw = {{36{f[31]}}, f};
        if (f > 32'sd0) begin
            if (v > fw)
                v = fw;
        end else begin
            if (v < fw)
                v = fw;
        end
        return sat32(v);
    endfunction

endpackage

@@ hdl/force_aligned_assist_pd_filter.sv @@
// channel | dir | beat payload                          | accepted when
// s_      | in  | force sample, muscle data, ready flag | s_tvalid & s_tready
// m_      | out | assist forces, PD terms, alpha        | m_tvalid & m_tready
// cfg_    | in  | register index and value              | cfg_valid & cfg_ready
// With the ready flag a beat runs through the shared 31-step divider (three
// uses, four when the angle falls on the ramp), the 32-step square root (two
// uses) and 17 CORDIC iterations, unless the force norm is zero.
// A beat without the flag is accepted and gives no result.
// Synchronous active-low reset; the control and config registers are reset.
// A held result stalls only the final load; the next beat may be taken meanwhile.
`include "force_aligned_assist_pd_filter_defines.svh"

module force_aligned_assist_pd_filter
    import faap_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // force_x, force_z, knee_moment, meas_force, ref_force,
    // dir_first, dir_second, dir_third
    input  logic [207:0] s_tdata,
    // companions_ready
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // assist_x, assist_z, assist_knee_torque, prop_term, deriv_term,
    // filtered_term, alpha_out, zero fill
    output logic [215:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    state_t state_reg, state_next;

    logic [23:0] pg_reg, tib_reg, inv_tib_reg;
    logic [30:0] dg_reg;
    logic [16:0] fc_reg, lim_reg, step_reg;

    logic [16:0]        alpha_reg, des_reg;
    logic signed [31:0] prev_err_reg, prev_filt_reg;

    logic signed [31:0] fx_reg, fz_reg, km_reg, meas_reg, refm_reg, f2_reg;
    logic signed [15:0] d0_reg, d1_reg, d2_reg;
    logic [31:0]        norm_reg;
    logic signed [31:0] u_reg [3];
    logic [1:0]         idx_reg;
    prod_t              acc_reg;
    logic signed [31:0] c_reg;
    logic signed [33:0] x_reg, y_reg;
    logic signed [19:0] z_reg;
    logic [4:0]         i_reg;
    logic signed [31:0] e_reg, prop_reg, der_reg, filt_reg;
    logic signed [31:0] ax_reg, az_reg, ak_reg;
    logic               m_valid_reg;
    logic [215:0]       m_data_reg;

    mul_op_t     op_a, op_b;
    prod_t       prod;
    logic        div_start, sq_start;
    logic [62:0] div_dvd;
    logic [31:0] div_dvs;
    logic [30:0] div_q;
    logic [63:0] sq_in;
    logic [31:0] sq_root;
    unit_stat_t  div_stat, sq_stat;

    logic               out_free;
    logic [16:0]        cc;
    logic [17:0]        angle;
    logic signed [31:0] f_sel;
    prod_t              dot_w;
    logic signed [33:0] xs, ys;
    logic [17:0]        a_sum;
    logic signed [18:0] a_dif;

    faap_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    faap_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_q),
        .stat     (div_stat)
    );

    faap_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_in),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        cc    = (fc_reg > ONE_Q16) ? ONE_Q16 : fc_reg;
        angle = z_reg[19] ? 18'd0 : z_reg[17:0];
        xs    = x_reg >>> i_reg;
        ys    = y_reg >>> i_reg;
        dot_w = rnd_shift(acc_reg + prod, 14);
        a_sum = {1'b0, alpha_reg} + {1'b0, step_reg};
        a_dif = $signed({2'b00, alpha_reg}) - $signed({2'b00, step_reg});
        unique case (idx_reg)
            2'd1:    f_sel = fz_reg;
            2'd2:    f_sel = f2_reg;
            default: f_sel = fx_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid && s_tuser[0]) state_next = S_KNEE;
            S_KNEE:    state_next = S_SQ0;
            S_SQ0:     state_next = S_SQ1;
            S_SQ1:     state_next = S_SQ2;
            S_SQ2:     state_next = S_SQ3;
            S_SQ3:     state_next = S_NORM;
            S_NORM:    if (sq_stat.done)
                           state_next = (sq_root == 32'd0) ? S_OUT : S_DIV_ISS;
            S_DIV_ISS: state_next = S_DIV;
            S_DIV:     if (div_stat.done)
                           state_next = (idx_reg == 2'd2) ? S_DOT0 : S_DIV_ISS;
            S_DOT0:    state_next = S_DOT1;
            S_DOT1:    state_next = S_DOT2;
            S_DOT2:    state_next = S_DOT3;
            S_DOT3:    state_next = S_CSQ;
            S_CSQ:     state_next = S_CSQ2;
            S_CSQ2:    state_next = S_YSQ;
            S_YSQ:     if (sq_stat.done) state_next = S_CORD;
            S_CORD:    if (i_reg == CORDIC_LAST) state_next = S_DES;
            S_DES:     begin
                priority if (angle >= HALF_PI_Q16) state_next = S_ALPHA;
                else if (angle > {1'b0, lim_reg})  state_next = S_DDIV;
                else                               state_next = S_ALPHA;
            end
            S_DDIV:    if (div_stat.done) state_next = S_ALPHA;
            S_ALPHA:   state_next = S_E_ISS;
            S_E_ISS:   state_next = S_E_GET;
            S_E_GET:   state_next = S_PD_ISS;
            S_PD_ISS:  state_next = S_PD_A;
            S_PD_A:    state_next = S_PD_B;
            S_PD_B:    state_next = S_F_ISS;
            S_F_ISS:   state_next = S_F_A;
            S_F_A:     state_next = S_F_B;
            S_F_B:     state_next = S_V_ISS;
            S_V_ISS:   state_next = S_V_A;
            S_V_A:     state_next = S_V_B;
            S_V_B:     state_next = S_V_C;
            S_V_C:     state_next = S_K_ISS;
            S_K_ISS:   state_next = S_K_GET;
            S_K_GET:   state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb begin
        op_a      = '0;
        op_b      = '0;
        div_start = 1'b0;
        sq_start  = 1'b0;
        div_dvd   = '0;
        div_dvs   = norm_reg;
        sq_in     = '0;
        unique case (state_reg)
            S_KNEE: begin
                op_a = sx32(km_reg);
                op_b = {10'd0, inv_tib_reg};
            end
            S_SQ0: begin
                op_a = {2'b00, abs32(fx_reg)};
                op_b = {2'b00, abs32(fx_reg)};
            end
            S_SQ1: begin
                op_a = {2'b00, abs32(fz_reg)};
                op_b = {2'b00, abs32(fz_reg)};
            end
            S_SQ2: begin
                op_a = {2'b00, abs32(f2_reg)};
                op_b = {2'b00, abs32(f2_reg)};
            end
            S_SQ3: begin
                sq_start = 1'b1;
                sq_in    = acc_reg[63:0] + prod[63:0];
            end
            S_DIV_ISS: begin
                div_start = 1'b1;
                div_dvd   = {1'b0, abs32(f_sel), 30'd0};
            end
            S_DOT0: begin
                op_a = sx32(u_reg[0]);
                op_b = {{18{d0_reg[15]}}, d0_reg};
            end
            S_DOT1: begin
                op_a = sx32(u_reg[1]);
                op_b = {{18{d1_reg[15]}}, d1_reg};
            end
            S_DOT2: begin
                op_a = sx32(u_reg[2]);
                op_b = {{18{d2_reg[15]}}, d2_reg};
            end
            S_CSQ: begin
                op_a = sx32(c_reg);
                op_b = sx32(c_reg);
            end
            S_CSQ2: begin
                sq_start = 1'b1;
                sq_in    = ONE_Q60 - prod[63:0];
            end
            S_DES: begin
                if (angle < HALF_PI_Q16 && angle > {1'b0, lim_reg}) begin
                    div_start = 1'b1;
                end
                div_dvd = {30'd0, 17'(HALF_PI_Q16 - angle), 16'd0};
                div_dvs = {15'd0, 17'(HALF_PI_Q16 - {1'b0, lim_reg})};
            end
            S_E_ISS: begin
                op_a = {17'd0, alpha_reg};
                op_b = sx33(sub33(refm_reg, meas_reg));
            end
            S_PD_ISS: begin
                op_a = {10'd0, pg_reg};
                op_b = sx32(e_reg);
            end
            S_PD_A: begin
                op_a = {3'd0, dg_reg};
                op_b = sx33(sub33(e_reg, prev_err_reg));
            end
            S_F_ISS: begin
                op_a = {17'd0, cc};
                op_b = sx32(prev_filt_reg);
            end
            S_F_A: begin
                op_a = sx33({prop_reg[31], prop_reg} + {der_reg[31], der_reg});
                op_b = {17'd0, 17'(ONE_Q16 - cc)};
            end
            S_V_ISS: begin
                op_a = sx32(filt_reg);
                op_b = sx32(u_reg[0]);
            end
            S_V_A: begin
                op_a = sx32(filt_reg);
                op_b = sx32(u_reg[1]);
            end
            S_V_B: begin
                op_a = sx32(filt_reg);
                op_b = sx32(u_reg[2]);
            end
            S_K_ISS: begin
                op_a = sx32(ak_reg);
                op_b = {10'd0, tib_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            pg_reg        <= 24'd65536;
            dg_reg        <= '0;
            fc_reg        <= '0;
            tib_reg       <= 24'd32768;
            inv_tib_reg   <= 24'd131072;
            lim_reg       <= 17'd51472;
            step_reg      <= 17'd6554;
            alpha_reg     <= '0;
            prev_err_reg  <= '0;
            prev_filt_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:  pg_reg      <= cfg_data[23:0];
                    CFG_DERIV_GAIN: dg_reg      <= cfg_data[30:0];
                    CFG_FILTER:     fc_reg      <= cfg_data[16:0];
                    CFG_TIBIA:      tib_reg     <= cfg_data[23:0];
                    CFG_INV_TIBIA:  inv_tib_reg <= cfg_data[23:0];
                    CFG_ANGLE_LIM:  lim_reg     <= cfg_data[16:0];
                    CFG_ALPHA_STEP: step_reg    <= cfg_data[16:0];
                    default: begin
                    end
                endcase
            end
            if (state_reg == S_OUT && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (state_reg == S_NORM && sq_stat.done && sq_root == 32'd0) begin
                alpha_reg     <= '0;
                prev_err_reg  <= '0;
                prev_filt_reg <= '0;
            end
            if (state_reg == S_ALPHA) begin
                if (des_reg > alpha_reg)
                    alpha_reg <= (a_sum < {1'b0, des_reg}) ? a_sum[16:0] : des_reg;
                else if (des_reg < alpha_reg)
                    alpha_reg <= (a_dif > $signed({2'b00, des_reg})) ? a_dif[16:0]
                                                                     : des_reg;
            end
            if (state_reg == S_F_B) begin
                prev_err_reg  <= e_reg;
                prev_filt_reg <= sat32(rnd_shift(acc_reg + prod, 16));
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                fx_reg   <= s_tdata[31:0];
                fz_reg   <= s_tdata[63:32];
                km_reg   <= s_tdata[95:64];
                meas_reg <= s_tdata[127:96];
                refm_reg <= s_tdata[159:128];
                d0_reg   <= s_tdata[175:160];
                d1_reg   <= s_tdata[191:176];
                d2_reg   <= s_tdata[207:192];
            end
            S_SQ0: f2_reg  <= sat32(rnd_shift(prod, 16));
            S_SQ1: acc_reg <= prod;
            S_SQ2: acc_reg <= acc_reg + prod;
            S_NORM: begin
                idx_reg <= 2'd0;
                if (sq_stat.done) begin
                    norm_reg <= sq_root;
                    ax_reg   <= '0;
                    az_reg   <= '0;
                    ak_reg   <= '0;
                    prop_reg <= '0;
                    der_reg  <= '0;
                    filt_reg <= '0;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    u_reg[idx_reg] <= f_sel[31] ? -$signed({1'b0, div_q})
                                                : $signed({1'b0, div_q});
                    idx_reg <= idx_reg + 2'd1;
                end
            end
            S_DOT1: acc_reg <= prod;
            S_DOT2: acc_reg <= acc_reg + prod;
            S_DOT3: begin
                priority if (dot_w > ONE_Q30_W) c_reg <= 32'sd1073741824;
                else if (dot_w < NEG_Q30_W)     c_reg <= -32'sd1073741824;
                else                            c_reg <= dot_w[31:0];
            end
            S_YSQ: begin
                i_reg <= '0;
                if (c_reg[31]) begin
                    x_reg <= {2'b00, sq_root};
                    y_reg <= -sx32(c_reg);
                    z_reg <= 20'(HALF_PI_Q16);
                end else begin
                    x_reg <= sx32(c_reg);
                    y_reg <= {2'b00, sq_root};
                    z_reg <= '0;
                end
            end
            S_CORD: begin
                i_reg <= i_reg + 5'd1;
                if (y_reg > 34'sd0) begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + $signed({4'd0, atan_q16(i_reg)});
                end else begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - $signed({4'd0, atan_q16(i_reg)});
                end
            end
            S_DES: begin
                priority if (angle >= HALF_PI_Q16) des_reg <= '0;
                else if (angle > {1'b0, lim_reg})  des_reg <= des_reg;
                else                               des_reg <= ONE_Q16;
            end
            S_DDIV:  if (div_stat.done) des_reg <= div_q[16:0];
            S_E_GET: e_reg    <= sat32(rnd_shift(prod, 16));
            S_PD_A:  prop_reg <= sat32(rnd_shift(prod, 16));
            S_PD_B:  der_reg  <= sat32(rnd_shift(prod, 16));
            S_F_A:   acc_reg  <= prod;
            S_F_B:   filt_reg <= sat32(rnd_shift(acc_reg + prod, 16));
            S_V_A:   ax_reg   <= clip32(prod, fx_reg);
            S_V_B:   az_reg   <= clip32(prod, fz_reg);
            S_V_C:   ak_reg   <= clip32(prod, f2_reg);
            S_K_GET: ak_reg   <= sat32(rnd_shift(prod, 16));
            S_OUT: begin
                if (out_free)
                    m_data_reg <= {7'd0, alpha_reg, filt_reg, der_reg, prop_reg,
                                   neg_sat32(ak_reg), neg_sat32(az_reg),
                                   neg_sat32(ax_reg)};
            end
            default: begin
            end
        endcase
    end

    `FAAP_ASSERT_IMP(a_alpha_range, aclk, aresetn, 1'b1, alpha_reg <= ONE_Q16)
    `FAAP_ASSERT_IMP(a_div_owner, aclk, aresetn, div_stat.busy, state_reg == S_DIV || state_reg == S_DDIV)
    `FAAP_ASSERT_IMP(a_sqrt_owner, aclk, aresetn, sq_stat.busy, state_reg == S_NORM || state_reg == S_YSQ)

endmodule

@@ hdl/faap_mul.sv @@
module faap_mul
    import faap_pkg::*;
(
    input  logic    aclk,
    input  mul_op_t op_a,
    input  mul_op_t op_b,
    output prod_t   prod
);

    prod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

@@ hdl/faap_div.sv @@
module faap_div
    import faap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [62:0] dividend,
    input  logic [31:0] divisor,
    output logic [30:0] quotient,
    output unit_stat_t  stat
);

    // quotient must fit 31 bits: dividend[62:31] < divisor
    logic [31:0] rem_reg, rem_next;
    logic [30:0] low_reg, q_reg, q_next;
    logic [31:0] dvs_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [32:0] trial;
    logic        take;

    always_comb begin
        trial    = {rem_reg, low_reg[30]};
        take     = trial >= {1'b0, dvs_reg};
        rem_next = take ? 32'(trial - {1'b0, dvs_reg}) : trial[31:0];
        q_next   = {q_reg[29:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd30;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[62:31];
            low_reg <= dividend[30:0];
            dvs_reg <= divisor;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[29:0], 1'b0};
            q_reg   <= q_next;
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ hdl/faap_sqrt.sv @@
module faap_sqrt
    import faap_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output unit_stat_t  stat
);

    logic [63:0] val_reg;
    logic [34:0] rem_reg, rem_shift, trial;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic        take;

    always_comb begin
        rem_shift = {rem_reg[32:0], val_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        take      = rem_shift >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd31;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            val_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[61:0], 2'b00};
            rem_reg  <= take ? rem_shift - trial : rem_shift;
            root_reg <= {root_reg[30:0], take};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
